// ----- hw/rtl/dnq_pkg.sv -----
// Shared types and constants for the deduplicating notification queue.
package dnq_pkg;

    // Request item taken on the command port
    typedef struct packed {
        logic        op;
        logic [63:0] key_low;
        logic [31:0] key_high;
        logic [7:0]  method;
        logic        host_ready;
        logic [31:0] now_ms;
        logic [7:0]  send_ok_mask;
    } t_item_in;

    // Result item driven on the result port
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [63:0] out_key_low;
        logic [31:0] out_key_high;
        logic [7:0]  out_method;
        logic [3:0]  pending;
        logic        last;
    } t_item_out;

    // Contents of one table slot
    typedef struct packed {
        logic        used;
        logic [63:0] key_low;
        logic [31:0] key_high;
        logic [7:0]  method;
    } t_slot;

    // Per-cell control: shift takes the upper neighbor, wr takes the new pair
    typedef struct packed {
        logic shift;
        logic wr;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_CMP,
        S_PUSH_WR,
        S_FLUSH_CHK,
        S_FLUSH_RUN
    } t_state;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [2:0] ST_DUP       = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_READY = 3'd4;
    localparam logic [2:0] ST_BACKOFF   = 3'd5;
    localparam logic [2:0] ST_SENT_OK   = 3'd6;
    localparam logic [2:0] ST_SENT_FAIL = 3'd7;

    localparam logic [15:0] BACKOFF_RESET = 16'd2000;

endpackage

// ----- hw/rtl/dnq_cell.sv -----
// One table slot: holds a key/method pair, compares it, shifts toward slot 0.
module dnq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dnq_pkg::t_cell_ctl i_ctl,
    input  dnq_pkg::t_slot    i_new,
    input  dnq_pkg::t_slot    i_nbr,
    output dnq_pkg::t_slot    o_slot,
    output logic              o_match
);

    logic        r_used;
    logic [63:0] r_key_low;
    logic [31:0] r_key_high;
    logic [7:0]  r_method;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_ctl.shift) begin
            r_used <= i_nbr.used;
        end else if (i_ctl.wr) begin
            r_used <= 1'b1;
        end
    end

    // payload needs no reset: only read while used is set
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key_low  <= i_nbr.key_low;
            r_key_high <= i_nbr.key_high;
            r_method   <= i_nbr.method;
        end else if (i_ctl.wr) begin
            r_key_low  <= i_new.key_low;
            r_key_high <= i_new.key_high;
            r_method   <= i_new.method;
        end
    end

    assign o_slot  = '{used: r_used, key_low: r_key_low, key_high: r_key_high,
                       method: r_method};
    assign o_match = r_used && (r_key_low == i_new.key_low) &&
                     (r_key_high == i_new.key_high) && (r_method == i_new.method);

endmodule

// ----- hw/rtl/dedup_notify_queue.sv -----
// Top level of the deduplicating notification queue: control and chain of slot cells.
//
// Usage
//   Command side: a request (push or flush) is transferred at a rising edge with
//   start high and busy low. Results leave on o_result, each valid for exactly
//   one cycle while o_strobe is high; the receiver cannot stall them.
//   o_result.last marks the final result of a request. The user must write
//   backoff_ms (i_cfg_we / i_cfg_wdata) only while idle; the block does not check.
// Sequence
//   Push: compare cycle, then write cycle; the single result is registered out of
//   the write cycle, and busy stays high through both.
//   Flush: a check cycle (empty / host not ready / backoff window). When it
//   sends, the slot chain rotates once around, one slot reaching cell 0 per
//   cycle; slot k's result is registered while slot k sits in cell 0.
//   A sending flush keeps busy high through the check and the whole rotation,
//   so the rotation of the cell chain sets the flush rate.
// Reset
//   Synchronous, active low: all slots free, backoff inactive with stamp zero,
//   backoff_ms back to 2000, no result pending.
module dedup_notify_queue #(
    parameter int DEPTH     = 8,
    parameter int KEY_BYTES = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  dnq_pkg::t_item_in  i_item,
    output logic               o_strobe,
    output dnq_pkg::t_item_out o_result,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);

    localparam int KW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // key bytes at or beyond KEY_BYTES never take part in storage or compare
    localparam logic [63:0] KeyLowMask = (KEY_BYTES >= 8) ? {64{1'b1}} :
                                         ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
    localparam logic [63:0] KeyHighWide = (KEY_BYTES <= 8) ? 64'd0 :
                                          ((64'd1 << (8 * (KEY_BYTES - 8))) - 64'd1);
    localparam logic [31:0] KeyHighMask = KeyHighWide[31:0];

    localparam logic [KW-1:0] LastK    = KW'(DEPTH - 1);
    localparam logic [4:0]    TopSlot  = 5'(DEPTH - 1);

    dnq_pkg::t_state    r_state, n_state;
    dnq_pkg::t_item_in  r_req, n_req;
    logic               r_dup, n_dup;
    logic [DEPTH-1:0]   r_sel, n_sel;
    logic [CW-1:0]      r_count, n_count;
    logic [KW-1:0]      r_k, n_k;
    logic [DEPTH-1:0]   r_todo, n_todo;
    logic               r_fail, n_fail;
    logic               r_active, n_active;
    logic [31:0]        r_stamp, n_stamp;
    logic [15:0]        r_backoff, n_backoff;
    logic               r_strobe, n_strobe;
    dnq_pkg::t_item_out r_result, n_result;

    dnq_pkg::t_slot     w_slot [DEPTH];
    dnq_pkg::t_slot     w_new;
    dnq_pkg::t_slot     w_top_in;
    dnq_pkg::t_cell_ctl w_ctl [DEPTH];
    logic [DEPTH-1:0]   w_match;
    logic [DEPTH-1:0]   w_used;
    logic [DEPTH-1:0]   w_free;
    logic [DEPTH-1:0]   w_cell_wr;
    logic               w_shift;
    logic [KW-1:0]      w_sel_enc;
    logic [4:0]         w_sel_ext;
    logic [4:0]         w_k_ext;
    logic [5:0]         w_cnt_ext;
    logic [CW-1:0]      w_cnt_dec;
    logic [5:0]         w_dec_ext;
    logic [31:0]        w_diff;
    logic               w_hold;
    logic               w_ok;
    logic               w_fail_all;

    // new pair, truncated to KEY_BYTES
    assign w_new = '{used: 1'b1, key_low: r_req.key_low & KeyLowMask,
                     key_high: r_req.key_high & KeyHighMask, method: r_req.method};

    // chain of cells: each cell shifts from its upper neighbor, top from w_top_in
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_ctl[g] = '{shift: w_shift, wr: w_cell_wr[g]};
        if (g == DEPTH - 1) begin : g_top
            dnq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_new   (w_new),
                .i_nbr   (w_top_in),
                .o_slot  (w_slot[g]),
                .o_match (w_match[g])
            );
        end else begin : g_mid
            dnq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_new   (w_new),
                .i_nbr   (w_slot[g+1]),
                .o_slot  (w_slot[g]),
                .o_match (w_match[g])
            );
        end
        assign w_used[g] = w_slot[g].used;
    end

    assign w_free = ~w_used;

    // one-hot select back to a slot number
    always_comb begin
        w_sel_enc = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_sel[i]) begin
                w_sel_enc = w_sel_enc | KW'(i);
            end
        end
    end

    assign w_sel_ext = 5'(w_sel_enc);
    assign w_k_ext   = 5'(r_k);
    assign w_cnt_ext = 6'(r_count);
    assign w_cnt_dec = r_count - CW'(1);
    assign w_dec_ext = 6'(w_cnt_dec);

    // backoff window: wrapping difference against the configured span
    assign w_diff = r_req.now_ms - r_stamp;
    assign w_hold = r_active && (w_diff < {16'd0, r_backoff});

    // slots beyond the eight mask bits always count as failed
    assign w_ok       = (w_k_ext < 5'd8) && r_req.send_ok_mask[w_k_ext[2:0]];
    assign w_fail_all = r_fail || (r_todo[0] && !w_ok);

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_dup     = r_dup;
        n_sel     = r_sel;
        n_count   = r_count;
        n_k       = r_k;
        n_todo    = r_todo;
        n_fail    = r_fail;
        n_active  = r_active;
        n_stamp   = r_stamp;
        n_backoff = r_backoff;
        n_strobe  = 1'b0;
        n_result  = '0;
        w_shift   = 1'b0;
        w_cell_wr = '0;
        w_top_in  = w_new;

        // backoff_ms register write
        if (i_cfg_we) begin
            n_backoff = i_cfg_wdata;
        end

        case (r_state)
            dnq_pkg::S_IDLE: begin
                if (start) begin
                    n_req   = i_item;
                    n_state = (i_item.op == dnq_pkg::OP_FLUSH) ? dnq_pkg::S_FLUSH_CHK :
                                                                 dnq_pkg::S_PUSH_CMP;
                end
            end
            dnq_pkg::S_PUSH_CMP: begin
                n_dup   = |w_match;
                // lowest free slot as a one-hot vector
                n_sel   = w_free & (~w_free + {{(DEPTH-1){1'b0}}, 1'b1});
                n_state = dnq_pkg::S_PUSH_WR;
            end
            dnq_pkg::S_PUSH_WR: begin
                n_strobe      = 1'b1;
                n_result.last = 1'b1;
                if (r_dup) begin
                    n_result.status  = dnq_pkg::ST_DUP;
                    n_result.pending = w_cnt_ext[3:0];
                end else if (|r_sel) begin
                    w_cell_wr        = r_sel;
                    n_count          = r_count + CW'(1);
                    n_result.status  = dnq_pkg::ST_INSERTED;
                    n_result.slot    = w_sel_ext[2:0];
                    n_result.pending = 4'(w_cnt_ext + 6'd1);
                end else begin
                    // full: everything moves down, slot 0 falls out
                    w_shift          = 1'b1;
                    n_result.status  = dnq_pkg::ST_DROPPED;
                    n_result.slot    = TopSlot[2:0];
                    n_result.pending = w_cnt_ext[3:0];
                end
                n_state = dnq_pkg::S_IDLE;
            end
            dnq_pkg::S_FLUSH_CHK: begin
                if (r_count == '0) begin
                    n_strobe        = 1'b1;
                    n_result.status = dnq_pkg::ST_EMPTY;
                    n_result.last   = 1'b1;
                    n_state         = dnq_pkg::S_IDLE;
                end else if (!r_req.host_ready) begin
                    n_strobe         = 1'b1;
                    n_result.status  = dnq_pkg::ST_NOT_READY;
                    n_result.pending = w_cnt_ext[3:0];
                    n_result.last    = 1'b1;
                    n_state          = dnq_pkg::S_IDLE;
                end else if (w_hold) begin
                    n_strobe         = 1'b1;
                    n_result.status  = dnq_pkg::ST_BACKOFF;
                    n_result.pending = w_cnt_ext[3:0];
                    n_result.last    = 1'b1;
                    n_state          = dnq_pkg::S_IDLE;
                end else begin
                    n_k     = '0;
                    n_todo  = w_used;
                    n_fail  = 1'b0;
                    n_state = dnq_pkg::S_FLUSH_RUN;
                end
            end
            dnq_pkg::S_FLUSH_RUN: begin
                // rotate: slot k sits in cell 0, wraps to the top freed if sent ok
                w_shift       = 1'b1;
                w_top_in      = w_slot[0];
                w_top_in.used = w_slot[0].used & ~(r_todo[0] & w_ok);
                if (r_todo[0]) begin
                    n_strobe              = 1'b1;
                    n_result.status       = w_ok ? dnq_pkg::ST_SENT_OK :
                                                   dnq_pkg::ST_SENT_FAIL;
                    n_result.slot         = w_k_ext[2:0];
                    n_result.out_key_low  = w_slot[0].key_low;
                    n_result.out_key_high = w_slot[0].key_high;
                    n_result.out_method   = w_slot[0].method;
                    n_result.pending      = w_ok ? w_dec_ext[3:0] : w_cnt_ext[3:0];
                    n_result.last         = (r_todo >> 1) == '0;
                    if (w_ok) begin
                        n_count = w_cnt_dec;
                    end
                end
                n_fail = w_fail_all;
                n_todo = r_todo >> 1;
                n_k    = r_k + KW'(1);
                if (r_k == LastK) begin
                    n_active = w_fail_all;
                    if (w_fail_all) begin
                        n_stamp = r_req.now_ms;
                    end
                    n_state = dnq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dnq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dnq_pkg::S_IDLE;
            r_count   <= '0;
            r_active  <= 1'b0;
            r_stamp   <= '0;
            r_backoff <= dnq_pkg::BACKOFF_RESET;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_active  <= n_active;
            r_stamp   <= n_stamp;
            r_backoff <= n_backoff;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_dup    <= n_dup;
        r_sel    <= n_sel;
        r_k      <= n_k;
        r_todo   <= n_todo;
        r_fail   <= n_fail;
        r_result <= n_result;
    end

    assign busy     = (r_state != dnq_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // a push always answers with one final result on o_strobe
    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.op == dnq_pkg::OP_PUSH)) |-> ##3 (o_strobe && o_result.last))
        else $error("push result missing");

    // the fill counter tracks the used bits of the chain
    a_count_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dnq_pkg::S_IDLE) |-> ($countones(w_used) == r_count))
        else $error("fill count out of step with used bits");

    // results only come out of work that was under way
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe while idle");

    // a skipped duplicate leaves the table alone
    a_dup_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == dnq_pkg::S_PUSH_WR) && r_dup) |=> $stable(w_used))
        else $error("duplicate push changed the table");

endmodule
